// ----- rtl/kic_pkg.sv -----
package kic_pkg;

    localparam int SLOT_W = 8;
    localparam int SIZE_W = 49;
    localparam int LEN_W = 48;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_MAP = 2'd2,
        REQ_UNMAP = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_HIT = 3'd0,
        ST_FREE = 3'd1,
        ST_EVICT = 3'd2,
        ST_BYPASS = 3'd3,
        ST_BADLEN = 3'd4,
        ST_NOCREATE = 3'd5,
        ST_COUNT_OK = 3'd6,
        ST_COUNT_ERR = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSTALL,
        OP_HIT,
        OP_HOLD_DEC,
        OP_MAP_INC,
        OP_MAP_DEC
    } op_t;

    typedef struct packed {
        logic [15:0] dev_type;
        logic [31:0] dev_number;
        logic [63:0] object_path;
        logic [31:0] object_version;
        logic [63:0] byte_offset;
        logic [SIZE_W-1:0] size;
    } key_t;

    // Partial scan result handed from one cell to the next.
    typedef struct packed {
        logic valid;
        logic hit;
        logic [SLOT_W-1:0] hit_idx;
        logic [7:0] hit_holder;
        logic free_found;
        logic [SLOT_W-1:0] free_idx;
        logic idle_found;
        logic [SLOT_W-1:0] idle_idx;
        logic [63:0] best_stamp;
        logic tgt_used;
        logic [7:0] tgt_holder;
        logic [7:0] tgt_mapper;
    } carry_t;

    typedef struct packed {
        op_t op;
        logic [SLOT_W-1:0] idx;
        logic [63:0] stamp;
    } cmd_t;

endpackage

// ----- rtl/keyed_image_cache_lru_pinned.sv -----
// Flow: page rounding of the segment length (four 16-bit digits, most significant first),
// a launch register, the registered entry cells along the scan chain, the scan latch and
// the commit, which offers the result on the output.
// Requests are taken one at a time, only in the idle state; a result that waits on
// m_tready holds the following request at its commit.
// Reset: asynchronous, active low; all entries become free, stamp clock zero.
module keyed_image_cache_lru_pinned #(
    parameter int NUM_ENTRIES = 16,
    parameter int PAGE_BYTES = 4096
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // dev_type, dev_number, object_path, object_version, byte_offset,
    // seg_length, create_ok, target_slot (from bit 0 up), zero padded
    input  logic [263:0] s_tdata,
    // req_type
    input  logic [1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // slot, victim_valid, victim_slot, rounded_size (from bit 0 up), zero padded
    output logic [63:0] m_tdata,
    // status
    output logic [2:0] m_tuser
);

    localparam int SW = kic_pkg::SLOT_W;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_SCAN, S_DONE} state_t;

    state_t state_reg;
    logic [1:0] req_reg;
    logic [15:0] dev_type_reg;
    logic [31:0] dev_number_reg;
    logic [63:0] path_reg;
    logic [31:0] version_reg;
    logic [63:0] offset_reg;
    logic [kic_pkg::LEN_W-1:0] len_reg;
    logic create_reg;
    logic [3:0] target_reg;
    logic [kic_pkg::SIZE_W-1:0] size_reg;
    logic [63:0] stamp_clock_reg;
    logic launch_reg;
    kic_pkg::carry_t scan_reg;
    logic m_tvalid_reg;
    kic_pkg::status_t status_reg;
    logic [3:0] slot_reg;
    logic vv_reg;
    logic [3:0] vs_reg;
    logic [kic_pkg::SIZE_W-1:0] out_size_reg;

    logic s_fire;
    logic [kic_pkg::SIZE_W-1:0] sum, remainder;
    logic div_done;
    kic_pkg::key_t key;
    kic_pkg::carry_t chain [NUM_ENTRIES+1];
    kic_pkg::cmd_t cmd;
    logic commit;
    kic_pkg::status_t st;
    logic [SW-1:0] res_idx;
    logic bump;
    logic tgt_bad;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire = s_tvalid && s_tready;
    assign sum = {1'b0, len_reg} + kic_pkg::SIZE_W'(PAGE_BYTES - 1);

    kic_pgrnd #(.PAGE_BYTES(PAGE_BYTES)) u_pgrnd (
        .clk(clk),
        .rst_n(rst_n),
        .start(state_reg == S_IDLE && s_fire),
        .dividend({1'b0, s_tdata[255:208]} + kic_pkg::SIZE_W'(PAGE_BYTES - 1)),
        .done(div_done),
        .remainder(remainder)
    );

    assign key = '{dev_type: dev_type_reg, dev_number: dev_number_reg,
                   object_path: path_reg, object_version: version_reg,
                   byte_offset: offset_reg, size: size_reg};

    assign chain[0] = '{valid: launch_reg, default: '0};

    for (genvar g = 0; g < NUM_ENTRIES; g++)
    begin : g_cell
        kic_cell #(.INDEX(g)) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .key(key),
            .target(SW'(target_reg)),
            .carry_in(chain[g]),
            .carry_out(chain[g+1]),
            .cmd(cmd)
        );
    end

    assign commit = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);
    assign tgt_bad = (int'(target_reg) >= NUM_ENTRIES) || !scan_reg.tgt_used;

    always_comb
    begin
        st = kic_pkg::ST_COUNT_ERR;
        res_idx = SW'(target_reg);
        bump = 1'b0;
        cmd.op = kic_pkg::OP_NONE;
        cmd.idx = '0;
        cmd.stamp = stamp_clock_reg + 64'd1;
        if (req_reg == kic_pkg::REQ_LOOKUP)
        begin
            res_idx = '0;
            priority if (len_reg == '0)
            begin
                st = kic_pkg::ST_BADLEN;
            end
            else if (scan_reg.hit)
            begin
                res_idx = scan_reg.hit_idx;
                if (scan_reg.hit_holder == 8'd255)
                begin
                    st = kic_pkg::ST_COUNT_ERR;
                end
                else
                begin
                    st = kic_pkg::ST_HIT;
                    cmd.op = kic_pkg::OP_HIT;
                    bump = 1'b1;
                end
            end
            else if (!create_reg)
            begin
                st = kic_pkg::ST_NOCREATE;
            end
            else if (scan_reg.free_found)
            begin
                st = kic_pkg::ST_FREE;
                res_idx = scan_reg.free_idx;
                cmd.op = kic_pkg::OP_INSTALL;
                bump = 1'b1;
            end
            else if (scan_reg.idle_found)
            begin
                st = kic_pkg::ST_EVICT;
                res_idx = scan_reg.idle_idx;
                cmd.op = kic_pkg::OP_INSTALL;
                bump = 1'b1;
            end
            else
            begin
                st = kic_pkg::ST_BYPASS;
            end
        end
        else if (!tgt_bad)
        begin
            unique case (req_reg)
                kic_pkg::REQ_RELEASE:
                begin
                    if (scan_reg.tgt_holder >= 8'd2)
                    begin
                        st = kic_pkg::ST_COUNT_OK;
                        cmd.op = kic_pkg::OP_HOLD_DEC;
                    end
                end
                kic_pkg::REQ_MAP:
                begin
                    if (scan_reg.tgt_holder >= 8'd2 && scan_reg.tgt_mapper != 8'd255)
                    begin
                        st = kic_pkg::ST_COUNT_OK;
                        cmd.op = kic_pkg::OP_MAP_INC;
                    end
                end
                default:
                begin
                    if (scan_reg.tgt_mapper != 8'd0)
                    begin
                        st = kic_pkg::ST_COUNT_OK;
                        cmd.op = kic_pkg::OP_MAP_DEC;
                    end
                end
            endcase
        end
        cmd.idx = res_idx;
        if (!commit)
        begin
            cmd.op = kic_pkg::OP_NONE;
            bump = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            launch_reg <= 1'b0;
            stamp_clock_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            launch_reg <= (state_reg == S_DIV) && div_done;
            if (commit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_fire)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (chain[NUM_ENTRIES].valid)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (commit)
                    begin
                        if (bump)
                        begin
                            stamp_clock_reg <= stamp_clock_reg + 64'd1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            req_reg <= s_tuser;
            dev_type_reg <= s_tdata[15:0];
            dev_number_reg <= s_tdata[47:16];
            path_reg <= s_tdata[111:48];
            version_reg <= s_tdata[143:112];
            offset_reg <= s_tdata[207:144];
            len_reg <= s_tdata[255:208];
            create_reg <= s_tdata[256];
            target_reg <= s_tdata[260:257];
        end
        if (state_reg == S_DIV && div_done)
        begin
            size_reg <= sum - remainder;
        end
        if (state_reg == S_SCAN && chain[NUM_ENTRIES].valid)
        begin
            scan_reg <= chain[NUM_ENTRIES];
        end
        if (commit)
        begin
            status_reg <= st;
            slot_reg <= res_idx[3:0];
            vv_reg <= (st == kic_pkg::ST_EVICT);
            vs_reg <= (st == kic_pkg::ST_EVICT) ? res_idx[3:0] : 4'd0;
            out_size_reg <= (req_reg == kic_pkg::REQ_LOOKUP && len_reg != '0)
                            ? size_reg : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser = status_reg;
    assign m_tdata = {6'd0, out_size_reg, vs_reg, vv_reg, slot_reg};

    a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain[NUM_ENTRIES].valid |-> state_reg == S_SCAN)
        else $error("scan token left the chain outside the scan phase");

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("page rounding finished outside its phase");

    a_cmd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op != kic_pkg::OP_NONE |-> int'(cmd.idx) < NUM_ENTRIES)
        else $error("entry update addressed beyond the table");

    a_stamp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_DONE |=> $stable(stamp_clock_reg))
        else $error("stamp clock moved outside commit");

endmodule

// ----- rtl/kic_pgrnd.sv -----
module kic_pgrnd #(
    parameter int PAGE_BYTES = 4096
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [kic_pkg::SIZE_W-1:0] dividend,
    output logic done,
    output logic [kic_pkg::SIZE_W-1:0] remainder
);

    localparam int DIG_W = 16;
    localparam int DIGITS = 4;
    localparam int DVD_W = DIG_W * DIGITS;
    localparam int CNT_W = $clog2(DIGITS + 1);
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(PAGE_BYTES));
    localparam logic [31:0] DIVISOR = 32'(PAGE_BYTES);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DIG_W-1:0] rem_reg, rem_next;
    logic [31:0] val_reg, val_next;
    logic [31:0] quot_reg, quot_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic phase_reg, phase_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [31:0] val;
    logic [64:0] prod;
    logic [48:0] back;
    logic [31:0] diff;

    // The remainder is reduced one 16-bit digit at a time, most significant first.
    // For each digit a reciprocal estimate of the quotient is formed first, then the
    // back-multiplication with one correcting subtraction.
    always_comb
    begin
        val = {rem_reg, dvd_reg[DVD_W-1 -: DIG_W]};
        prod = 65'(val) * 65'(RECIP);
        back = 49'(quot_reg) * 49'(DIVISOR);
        diff = val_reg - back[31:0];
        if (diff >= DIVISOR)
        begin
            diff = diff - DIVISOR;
        end
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        val_next = val_reg;
        quot_next = quot_reg;
        cnt_next = cnt_reg;
        phase_next = phase_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next = DVD_W'(dividend);
            rem_next = '0;
            cnt_next = CNT_W'(DIGITS);
            phase_next = 1'b0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                val_next = val;
                quot_next = prod[63:32];
                dvd_next = dvd_reg << DIG_W;
                phase_next = 1'b1;
            end
            else
            begin
                rem_next = diff[DIG_W-1:0];
                cnt_next = cnt_reg - 1'b1;
                phase_next = 1'b0;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        val_reg <= val_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign remainder = kic_pkg::SIZE_W'(rem_reg);

endmodule

// ----- rtl/kic_cell.sv -----
module kic_cell #(
    parameter int INDEX = 0
) (
    input  logic clk,
    input  logic rst_n,
    input  kic_pkg::key_t key,
    input  logic [kic_pkg::SLOT_W-1:0] target,
    input  kic_pkg::carry_t carry_in,
    output kic_pkg::carry_t carry_out,
    input  kic_pkg::cmd_t cmd
);

    localparam logic [kic_pkg::SLOT_W-1:0] MY_IDX = kic_pkg::SLOT_W'(INDEX);

    logic used_reg;
    kic_pkg::key_t key_reg;
    logic [7:0] holder_reg;
    logic [7:0] mapper_reg;
    logic [63:0] stamp_reg;
    kic_pkg::carry_t carry_reg, carry_next;
    logic valid_reg;
    logic match, idle, sel;

    assign match = used_reg && (key_reg == key);
    assign idle = used_reg && (holder_reg == 8'd1) && (mapper_reg == 8'd0);
    assign sel = (cmd.idx == MY_IDX);

    always_comb
    begin
        carry_next = carry_in;
        if (!carry_in.hit && match)
        begin
            carry_next.hit = 1'b1;
            carry_next.hit_idx = MY_IDX;
            carry_next.hit_holder = holder_reg;
        end
        if (!carry_in.free_found && !used_reg)
        begin
            carry_next.free_found = 1'b1;
            carry_next.free_idx = MY_IDX;
        end
        if (idle && (!carry_in.idle_found || stamp_reg < carry_in.best_stamp))
        begin
            carry_next.idle_found = 1'b1;
            carry_next.idle_idx = MY_IDX;
            carry_next.best_stamp = stamp_reg;
        end
        if (target == MY_IDX)
        begin
            carry_next.tgt_used = used_reg;
            carry_next.tgt_holder = holder_reg;
            carry_next.tgt_mapper = mapper_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= carry_in.valid;
            if (sel && cmd.op == kic_pkg::OP_INSTALL)
            begin
                used_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        if (sel)
        begin
            unique case (cmd.op)
                kic_pkg::OP_INSTALL:
                begin
                    key_reg <= key;
                    holder_reg <= 8'd2;
                    mapper_reg <= 8'd0;
                    stamp_reg <= cmd.stamp;
                end
                kic_pkg::OP_HIT:
                begin
                    holder_reg <= holder_reg + 8'd1;
                    stamp_reg <= cmd.stamp;
                end
                kic_pkg::OP_HOLD_DEC: holder_reg <= holder_reg - 8'd1;
                kic_pkg::OP_MAP_INC: mapper_reg <= mapper_reg + 8'd1;
                kic_pkg::OP_MAP_DEC: mapper_reg <= mapper_reg - 8'd1;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        carry_out = carry_reg;
        carry_out.valid = valid_reg;
    end

endmodule
